[sv/scld_pkg.sv]
// Package for the serial command line decoder: result codes, decoder states, byte codes,
// the keyword table and its lookup helper.
// No dependencies.
`default_nettype none

package scld_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int KW_MAX_LEN        = 16;
    localparam int NUM_KW            = 23;

    typedef enum logic [3:0] {
        OC_PING       = 4'd0,
        OC_STATUS     = 4'd1,
        OC_BATTERY    = 4'd2,
        OC_TEMP       = 4'd3,
        OC_STATE      = 4'd4,
        OC_SYNC_START = 4'd5,
        OC_SYNC_STAT  = 4'd6,
        OC_SYNC_STOP  = 4'd7,
        OC_STOP       = 4'd8,
        OC_AUTO       = 4'd9,
        OC_HELP       = 4'd10,
        OC_UNKNOWN    = 4'd11,
        OC_TOO_LONG   = 4'd12
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } dec_state_t;

    typedef logic [NUM_KW-1:0] kw_mask_t;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Text is right-aligned: the last character sits in the low byte.
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
        "PING", "STATUS", "GET STATUS",
        "BATTERY", "GET BATTERY",
        "TEMP", "TEMPERATURE", "GET TEMP",
        "STATE", "GET STATE",
        "TSYNC START", "TEMP SYNC START",
        "TSYNC STATUS", "TEMP SYNC STATUS",
        "TSYNC STOP", "TEMP SYNC STOP",
        "STOP", "OFF", "CHARGE OFF",
        "AUTO", "CHARGE AUTO",
        "HELP", "?"
    };

    localparam logic [4:0] KW_LEN [NUM_KW] = '{
        5'd4, 5'd6, 5'd10,
        5'd7, 5'd11,
        5'd4, 5'd11, 5'd8,
        5'd5, 5'd9,
        5'd11, 5'd15,
        5'd12, 5'd16,
        5'd10, 5'd14,
        5'd4, 5'd3, 5'd10,
        5'd4, 5'd11,
        5'd4, 5'd1
    };

    localparam outcome_t KW_CODE [NUM_KW] = '{
        OC_PING, OC_STATUS, OC_STATUS,
        OC_BATTERY, OC_BATTERY,
        OC_TEMP, OC_TEMP, OC_TEMP,
        OC_STATE, OC_STATE,
        OC_SYNC_START, OC_SYNC_START,
        OC_SYNC_STAT, OC_SYNC_STAT,
        OC_SYNC_STOP, OC_SYNC_STOP,
        OC_STOP, OC_STOP, OC_STOP,
        OC_AUTO, OC_AUTO,
        OC_HELP, OC_HELP
    };

    // Character of keyword k at position pos; only meaningful for pos < length.
    function automatic logic [6:0] kw_char(input int unsigned k, input logic [4:0] pos);
        logic [8*KW_MAX_LEN-1:0] txt;
        logic [4:0]              sh;
        txt = KW_TEXT[k];
        sh  = KW_LEN[k] - pos - 5'd1;
        return txt[{sh[3:0], 3'b000} +: 7];
    endfunction

endpackage

`default_nettype wire

[sv/scld_if.sv]
// Valid/ready channel interfaces for the serial command line decoder.
// Uses no package; payload widths are fixed by the byte and result fields.
`default_nettype none

interface scld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scld_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] outcome;

    modport source (output valid, output outcome, input ready);
    modport sink   (input valid, input outcome, output ready);
endinterface

`default_nettype wire

[sv/serial_command_line_decoder_unit.sv]
// Serial command line decoder: assembles received bytes into a line store
// and decodes a line into a command code on newline.
// Depends on scld_pkg and the channel interfaces in scld_if.sv.
//
// Usage:
//   rx  : one received byte per item. Carriage return, control bytes and
//         bytes above '~' are dropped; backspace/DEL removes a character.
//   res : zero or one outcome per byte. A newline yields a command code or
//         unknown (nothing for a blank line); the byte that overflows the
//         store yields too-long, and the rest of that line is skipped.
// Timing: ordinary bytes are accepted in the idle state. A newline walks the line
//   store through its single read port, one stored character per cycle, and
//   rx.ready is low meanwhile. The result is then loaded into an output register.
// Stalls: while a result waits in the output register and res.ready is low,
//   rx.ready is held low; no item is lost.
// Reset: empties the line, clears the skip flag and the output valid flag.
//   The line store itself is not cleared; only written entries are read.
`default_nettype none

module serial_command_line_decoder_unit #(
    parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    scld_rx_if.sink      rx,
    scld_res_if.source   res
);
    import scld_pkg::*;

    localparam int DEPTH  = LINE_CAPACITY - 1;
    localparam int CNT_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Line store
    logic [6:0] line_mem [DEPTH];
    logic [6:0] rdata_reg;

    dec_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             discard_reg, discard_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rvalid_reg;
    kw_mask_t         alive_reg, alive_next;
    logic [4:0]       nlen_reg, nlen_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    outcome_t         out_code_reg, out_code_next;

    logic             slot_free;
    logic             rx_take;
    logic             issue;
    logic             wr_en;
    logic [6:0]       ch_up;
    kw_mask_t         alive_a;
    kw_mask_t         alive_b;
    logic [4:0]       nlen_a;
    logic [4:0]       nlen_b;
    logic             kw_hit;
    outcome_t         kw_code;

    function automatic kw_mask_t match_step(input kw_mask_t alive, input logic [4:0] pos,
                                            input logic [6:0] ch);
        kw_mask_t m;
        for (int k = 0; k < NUM_KW; k++)
        begin
            m[k] = alive[k] && (pos < KW_LEN[k]) && (kw_char(k, pos) == ch);
        end
        return m;
    endfunction

    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == 5'h1F) ? v : v + 5'd1;
    endfunction

    assign slot_free   = !out_valid_reg || res.ready;
    assign res.valid   = out_valid_reg;
    assign res.outcome = out_code_reg;
    assign rx_take     = rx.valid && rx.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_take && rx.rx_byte == CH_LF && !discard_reg)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!issue && !rvalid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (nlen_reg == 5'd0 || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        rx.ready = 1'b0;
        issue    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rx.ready = slot_free;
            end
            ST_WALK:
            begin
                issue = (rd_idx_reg < fill_reg);
            end
            ST_FINISH:
            begin
                rx.ready = 1'b0;
            end
            default:
            begin
                rx.ready = 1'b0;
            end
        endcase
    end

    // Normalise and match one stored character
    always_comb
    begin
        ch_up = rdata_reg;
        if (rdata_reg inside {[7'h61:7'h7A]})
        begin
            ch_up = rdata_reg - 7'h20;
        end
        if (pend_reg)
        begin
            alive_a = match_step(alive_reg, nlen_reg, CH_SPACE[6:0]);
            nlen_a  = sat_inc(nlen_reg);
        end
        else
        begin
            alive_a = alive_reg;
            nlen_a  = nlen_reg;
        end
        alive_b = match_step(alive_a, nlen_a, ch_up);
        nlen_b  = sat_inc(nlen_a);
    end

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_code = OC_UNKNOWN;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (alive_reg[k] && KW_LEN[k] == nlen_reg)
            begin
                kw_hit  = 1'b1;
                kw_code = KW_CODE[k];
            end
        end
    end

    // Datapath next values
    always_comb
    begin
        fill_next      = fill_reg;
        discard_next   = discard_reg;
        rd_idx_next    = rd_idx_reg;
        alive_next     = alive_reg;
        nlen_next      = nlen_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_code_next  = out_code_reg;
        wr_en          = 1'b0;

        if (state_reg == ST_IDLE && rx_take)
        begin
            if (rx.rx_byte == CH_CR)
            begin
                fill_next = fill_reg;
            end
            else if (rx.rx_byte == CH_LF)
            begin
                if (discard_reg)
                begin
                    discard_next = 1'b0;
                    fill_next    = '0;
                end
                else
                begin
                    rd_idx_next = '0;
                    alive_next  = '1;
                    nlen_next   = 5'd0;
                    pend_next   = 1'b0;
                end
            end
            else if (discard_reg)
            begin
                discard_next = 1'b1;
            end
            else if (rx.rx_byte == CH_BS || rx.rx_byte == CH_DEL)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            else if (rx.rx_byte < CH_SPACE || rx.rx_byte > CH_TILDE)
            begin
                fill_next = fill_reg;
            end
            else if (fill_reg >= DEPTH_C)
            begin
                discard_next   = 1'b1;
                fill_next      = '0;
                out_valid_next = 1'b1;
                out_code_next  = OC_TOO_LONG;
            end
            else
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end
        end

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        if (state_reg == ST_WALK && rvalid_reg)
        begin
            if (rdata_reg == CH_SPACE[6:0])
            begin
                pend_next = (nlen_reg != 5'd0);
            end
            else
            begin
                alive_next = alive_b;
                nlen_next  = nlen_b;
                pend_next  = 1'b0;
            end
        end

        if (state_reg == ST_FINISH)
        begin
            if (nlen_reg == 5'd0)
            begin
                fill_next = '0;
            end
            else if (slot_free)
            begin
                fill_next      = '0;
                out_valid_next = 1'b1;
                out_code_next  = kw_hit ? kw_code : OC_UNKNOWN;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            discard_reg   <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            discard_reg   <= discard_next;
            rvalid_reg    <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        alive_reg    <= alive_next;
        nlen_reg     <= nlen_next;
        pend_reg     <= pend_next;
        out_code_reg <= out_code_next;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[fill_reg[ADDR_W-1:0]] <= rx.rx_byte[6:0];
        end
        if (issue)
        begin
            rdata_reg <= line_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= DEPTH_C)
        else $error("line fill count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n) discard_reg |-> fill_reg == '0)
        else $error("characters held while skipping an overlong line");

    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg != ST_IDLE |-> !rx.ready)
        else $error("byte accepted during line walk");

    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(out_valid_reg) |->
                     $past(state_reg == ST_IDLE || state_reg == ST_FINISH))
        else $error("result loaded in the middle of a line walk");

endmodule

`default_nettype wire

[dv/serial_command_line_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for serial_command_line_decoder_unit: random command lines, noise and
// overlong lines are fed in and every outcome is checked against a line predictor.
// Depends on scld_pkg, the channel interfaces in scld_if.sv and the decoder itself.

module serial_command_line_decoder_unit_tb;

    import scld_pkg::*;

    localparam int LINE_CAP    = LINE_CAPACITY_DEF;
    localparam int STORE_DEPTH = LINE_CAP - 1;
    localparam int NUM_WORDS   = 23;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n;

    scld_rx_if  rx ();
    scld_res_if res ();

    serial_command_line_decoder_unit #(
        .LINE_CAPACITY(LINE_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0]  rx_bytes_q [$];
    outcome_t    outcome_q [$];
    int          pushed     = 0;
    int          fail_count = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    bit          hold_go    = 1'b0;
    bit          hold_off   = 1'b0;

    // Line predictor state
    logic [6:0]  line_buf [STORE_DEPTH];
    int unsigned line_len = 0;
    bit          skipping = 1'b0;

    function automatic outcome_t command_code(input int k);
        outcome_t c;
        case (k)
            0:       c = OC_PING;
            1, 2:    c = OC_STATUS;
            3, 4:    c = OC_BATTERY;
            5, 6, 7: c = OC_TEMP;
            8, 9:    c = OC_STATE;
            10, 11:  c = OC_SYNC_START;
            12, 13:  c = OC_SYNC_STAT;
            14, 15:  c = OC_SYNC_STOP;
            16, 17, 18: c = OC_STOP;
            19, 20:  c = OC_AUTO;
            default: c = OC_HELP;
        endcase
        return c;
    endfunction

    function automatic string command_word(input int k, output outcome_t code);
        string w;
        code = command_code(k);
        case (k)
            0:       w = "PING";
            1:       w = "STATUS";
            2:       w = "GET STATUS";
            3:       w = "BATTERY";
            4:       w = "GET BATTERY";
            5:       w = "TEMP";
            6:       w = "TEMPERATURE";
            7:       w = "GET TEMP";
            8:       w = "STATE";
            9:       w = "GET STATE";
            10:      w = "TSYNC START";
            11:      w = "TEMP SYNC START";
            12:      w = "TSYNC STATUS";
            13:      w = "TEMP SYNC STATUS";
            14:      w = "TSYNC STOP";
            15:      w = "TEMP SYNC STOP";
            16:      w = "STOP";
            17:      w = "OFF";
            18:      w = "CHARGE OFF";
            19:      w = "AUTO";
            20:      w = "CHARGE AUTO";
            21:      w = "HELP";
            default: w = "?";
        endcase
        return w;
    endfunction

    // Advance the line predictor by one byte; returns 1 when an outcome is due.
    function automatic bit decode_byte(input logic [7:0] b, output outcome_t oc);
        logic [7:0]  norm [STORE_DEPTH];
        int unsigned n;
        int          i;
        int          k;
        bit          gap;
        bit          same;
        string       w;
        outcome_t    code;
        oc  = OC_UNKNOWN;
        n   = 0;
        gap = 1'b0;
        if (b == CH_CR)
            return 1'b0;
        if (b == CH_LF)
        begin
            if (skipping)
            begin
                skipping = 1'b0;
                line_len = 0;
                return 1'b0;
            end
            for (i = 0; i < line_len; i++)
            begin
                if (line_buf[i] == CH_SPACE[6:0])
                begin
                    gap = (n > 0);
                    continue;
                end
                if (gap)
                begin
                    norm[n] = CH_SPACE;
                    n++;
                end
                gap = 1'b0;
                if (line_buf[i] >= 7'h61 && line_buf[i] <= 7'h7A)
                    norm[n] = {1'b0, line_buf[i] - 7'd32};
                else
                    norm[n] = {1'b0, line_buf[i]};
                n++;
            end
            line_len = 0;
            if (n == 0)
                return 1'b0;
            for (k = 0; k < NUM_WORDS; k++)
            begin
                w = command_word(k, code);
                if (w.len() == n)
                begin
                    same = 1'b1;
                    for (i = 0; i < n; i++)
                        if (w[i] != norm[i])
                            same = 1'b0;
                    if (same)
                    begin
                        oc = code;
                        return 1'b1;
                    end
                end
            end
            return 1'b1;
        end
        if (skipping)
            return 1'b0;
        if (b == CH_BS || b == CH_DEL)
        begin
            if (line_len > 0)
                line_len--;
            return 1'b0;
        end
        if (b < CH_SPACE || b > CH_TILDE)
            return 1'b0;
        if (line_len >= STORE_DEPTH)
        begin
            skipping = 1'b1;
            line_len = 0;
            oc       = OC_TOO_LONG;
            return 1'b1;
        end
        line_buf[line_len] = b[6:0];
        line_len++;
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        pushed++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Keyword line with random case, padding, repeated inner spaces and corrected typos.
    task automatic push_command_line(input int k);
        string      w;
        outcome_t   code;
        int         i;
        logic [7:0] ch;
        w = command_word(k, code);
        repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
        for (i = 0; i < w.len(); i++)
        begin
            ch = w[i];
            if (ch == CH_SPACE)
                repeat ($urandom_range(1, 3)) push_byte(CH_SPACE);
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_byte(8'($urandom_range(8'h21, 8'h7E)));
                    push_byte($urandom_range(1) ? CH_BS : CH_DEL);
                end
                if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(1))
                    ch = ch + 8'd32;
                push_byte(ch);
            end
        end
        repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
        if ($urandom_range(3) == 0)
            push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic run_phase(input int send_gap, input int recv_gap, input int n_items);
        int       stop_at;
        int       kind;
        int       n;
        int       i;
        string    w;
        outcome_t code;
        @(negedge clk);
        idle_pct  = send_gap;
        stall_pct = recv_gap;
        stop_at   = pushed + n_items;
        while (pushed < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
                push_command_line($urandom_range(NUM_WORDS - 1));
            else if (kind < 68)
            begin
                // near miss: keyword cut short or with a stray letter appended
                w = command_word($urandom_range(NUM_WORDS - 1), code);
                n = $urandom_range(1) ? w.len() - 1 : w.len();
                for (i = 0; i < n; i++)
                    push_byte(w[i]);
                if (n == w.len())
                    push_byte(8'($urandom_range(8'h41, 8'h5A)));
                push_byte(CH_LF);
            end
            else if (kind < 78)
            begin
                repeat ($urandom_range(1, 20))
                    push_byte(($urandom_range(3) == 0)
                              ? 8'($urandom_range(0, 255))
                              : 8'($urandom_range(8'h20, 8'h7E)));
                push_byte(CH_LF);
            end
            else if (kind < 88)
            begin
                // fill the store exactly, or overflow it and trail junk to be skipped
                n = STORE_DEPTH + $urandom_range(0, 3);
                repeat (n) push_byte(8'($urandom_range(8'h20, 8'h7E)));
                if (n == STORE_DEPTH && $urandom_range(1))
                begin
                    push_byte(CH_DEL);
                    push_byte(8'($urandom_range(8'h21, 8'h7E)));
                end
                repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_LF);
            end
            else if (kind < 95)
            begin
                repeat ($urandom_range(0, 4)) push_byte($urandom_range(1) ? CH_SPACE : CH_CR);
                push_byte(CH_LF);
            end
            else
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
        end
        while (rx_bytes_q.size() != 0)
            @(negedge clk);
    endtask

    // Byte driver: predict each accepted item, then offer the next one.
    always @(posedge clk)
    begin : drive_rx
        outcome_t oc_next;
        if (!rst_n)
        begin
            rx.valid   <= 1'b0;
            rx.rx_byte <= '0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                if (decode_byte(rx.rx_byte, oc_next))
                    outcome_q.push_back(oc_next);
            if (!rx.valid || rx.ready)
            begin
                if (rx_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    rx.valid   <= 1'b1;
                    rx.rx_byte <= rx_bytes_q.pop_front();
                end
                else
                    rx.valid <= 1'b0;
            end
        end
    end

    // Outcome monitor and receiver back-pressure.
    always @(posedge clk)
    begin : watch_res
        outcome_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected outcome: expected none, actual %0d",
                             $time, res.outcome);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (res.outcome !== want)
                    begin
                        $display("%0t: outcome mismatch: expected %0d, actual %0d",
                                 $time, want, res.outcome);
                        fail_count++;
                    end
                end
            end
            res.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold-off so that the output register fills and the input stalls.
    initial
    begin : long_hold
        wait (hold_go);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : run_limit
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: help shortcut, bare CR/LF, blank line, erase on empty line,
        // dropped control and high bytes, erase mid-line, tilde.
        push_text("?");
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_text("  ");
        push_byte(CH_LF);
        push_byte(CH_BS);
        push_byte(CH_DEL);
        push_text(" oFq");
        push_byte(CH_DEL);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h1F);
        push_byte(8'h80);
        push_text("f ");
        push_byte(CH_LF);
        push_text("~");
        push_byte(CH_LF);
        while (rx_bytes_q.size() != 0)
            @(negedge clk);

        run_phase(0, 0, 75);
        run_phase(58, 0, 75);
        run_phase(0, 58, 75);
        run_phase(22, 22, 75);

        // Keep offering short commands while the receiver holds off.
        @(negedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (10) push_command_line($urandom_range(NUM_WORDS - 1));
        while (rx_bytes_q.size() != 0)
            @(negedge clk);

        run_phase(0, 0, 50);

        while (outcome_q.size() != 0 || rx.valid)
            @(negedge clk);
        repeat (LINE_CAP + 8) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
sv/scld_pkg.sv
sv/scld_if.sv
sv/serial_command_line_decoder_unit.sv
dv/serial_command_line_decoder_unit_tb.sv
